FILE: design/rfp_pkg.sv
// shared types, field codes and helpers for the record field parser
// no dependencies; imported by every rfp module and the top level
`default_nettype none

package rfp_pkg;

  localparam int OFFSET_BITS_DEFAULT = 32;
  localparam int START_BITS          = 32;
  localparam int TDATA_OUT_BITS      = 136;

  // output tdata layout, lowest bit first
  localparam int TD_CODE_LSB  = 0;
  localparam int TD_PIDX_LSB  = 4;
  localparam int TD_VALUE_LSB = 36;
  localparam int TD_START_LSB = 100;
  localparam int TD_DONE_BIT  = 132;

  typedef logic [3:0] field_code_t;
  typedef logic [4:0] phase_t;

  localparam field_code_t FC_NAME         = 4'd0;
  localparam field_code_t FC_PARAM_COUNT  = 4'd4;
  localparam field_code_t FC_ADDRESS      = 4'd5;
  localparam field_code_t FC_DISPLAY_NAME = 4'd6;
  localparam field_code_t FC_UNIT         = 4'd8;
  localparam field_code_t FC_WRITABLE     = 4'd14;
  localparam field_code_t FC_RAMP         = 4'd15;

  localparam phase_t PHASE_START = {1'b0, FC_NAME};
  localparam phase_t PHASE_DONE  = 5'd31;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_TRUNC = 1'b1;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } rfp_item_t;

  typedef struct packed {
    logic                  result_status;
    field_code_t           field_code;
    logic [31:0]           param_index;
    logic [63:0]           field_value;
    logic [START_BITS-1:0] string_start;
    logic                  record_done;
  } rfp_result_t;

  function automatic logic is_string(input field_code_t code);
    return (code < FC_PARAM_COUNT) || ((code >= FC_DISPLAY_NAME) && (code <= FC_UNIT));
  endfunction

  // index of the final byte of a prefix or primitive
  function automatic logic [2:0] field_last_byte(input field_code_t code);
    logic [2:0] last;
    if (code == FC_ADDRESS) begin
      last = 3'd7;
    end else if (code >= FC_WRITABLE) begin
      last = 3'd0;
    end else begin
      last = 3'd3;
    end
    return last;
  endfunction

endpackage

`default_nettype wire

FILE: design/rfp_in_reg.sv
// input register of the record field parser: holds one accepted byte transaction
// depends on rfp_pkg
`default_nettype none

module rfp_in_reg
  import rfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // data_byte
  input  wire logic       s_tuser,   // has_byte
  input  wire logic       s_tlast,   // end_of_buffer
  input  wire logic       step,
  output rfp_item_t       item,
  output logic            item_valid
);

  logic accept;

  assign s_tready = !item_valid || step;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (step) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.has_byte      <= s_tuser;
      item.data_byte     <= s_tdata;
      item.end_of_buffer <= s_tlast;
    end
  end

endmodule

`default_nettype wire

FILE: design/rfp_walker.sv
// schema walker: parser state registers and the per-byte decode step
// depends on rfp_pkg; produces up to two results per transaction
`default_nettype none

module rfp_walker
  import rfp_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire rfp_item_t  item,
  output rfp_result_t     res0,
  output rfp_result_t     res1,
  output logic [1:0]      res_cnt
);

  phase_t                 phase, phase_next;
  logic [2:0]             biw, biw_next;
  logic [63:0]            acc, acc_next;
  logic [31:0]            left, left_next;
  logic [31:0]            params, params_next;
  logic [31:0]            cur, cur_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [OFFSET_BITS-1:0] origin, origin_next;
  logic                   complete, complete_next;

  logic [OFFSET_BITS-1:0] pos_inc;
  logic [START_BITS-1:0]  origin_s, pos_inc_s;
  logic [63:0]            acc_new;
  field_code_t            code;
  rfp_result_t            fres, eres;
  logic                   f_valid, e_valid, adv;
  logic [63:0]            adv_value;

  assign pos_inc = pos + 1'b1;
  assign code    = phase[3:0];

  if (OFFSET_BITS >= START_BITS) begin : g_wide_offset
    assign origin_s  = origin[START_BITS-1:0];
    assign pos_inc_s = pos_inc[START_BITS-1:0];
  end else begin : g_narrow_offset
    assign origin_s  = {{(START_BITS-OFFSET_BITS){1'b0}}, origin};
    assign pos_inc_s = {{(START_BITS-OFFSET_BITS){1'b0}}, pos_inc};
  end

  // little-endian byte lanes
  always_comb begin
    acc_new = acc;
    for (int i = 0; i < 8; i++) begin
      if (biw == 3'(i)) begin
        acc_new[8*i +: 8] = acc[8*i +: 8] | item.data_byte;
      end
    end
  end

  always_comb begin
    phase_next    = phase;
    biw_next      = biw;
    acc_next      = acc;
    left_next     = left;
    params_next   = params;
    cur_next      = cur;
    pos_next      = pos;
    origin_next   = origin;
    complete_next = complete;
    f_valid       = 1'b0;
    adv           = 1'b0;
    adv_value     = '0;
    fres          = '0;

    if (item.has_byte && !complete) begin
      pos_next = pos_inc;
      if (phase[4]) begin
        left_next = left - 32'd1;
        if (left == 32'd1) begin
          f_valid           = 1'b1;
          fres.field_value  = acc;
          fres.string_start = origin_s;
          adv               = 1'b1;
          adv_value         = acc;
        end
      end else if (biw == field_last_byte(code)) begin
        if (!is_string(code)) begin
          f_valid          = 1'b1;
          fres.field_value = acc_new;
          adv              = 1'b1;
          adv_value        = acc_new;
        end else if (acc_new == '0) begin
          // empty string reported as soon as its prefix is complete
          f_valid           = 1'b1;
          fres.string_start = pos_inc_s;
          adv               = 1'b1;
        end else begin
          origin_next = pos_inc;
          left_next   = acc_new[31:0];
          biw_next    = '0;
          acc_next    = acc_new;
          phase_next  = {1'b1, code};
        end
      end else begin
        acc_next = acc_new;
        biw_next = biw + 3'd1;
      end

      if (adv) begin
        acc_next  = '0;
        biw_next  = '0;
        left_next = '0;
        if (code == FC_PARAM_COUNT) begin
          params_next = adv_value[31:0];
          cur_next    = '0;
          if (adv_value[31:0] == '0) begin
            phase_next    = PHASE_DONE;
            complete_next = 1'b1;
          end else begin
            phase_next = {1'b0, FC_ADDRESS};
          end
        end else if (code == FC_RAMP) begin
          params_next = params - 32'd1;
          if (params == 32'd1) begin
            phase_next    = PHASE_DONE;
            complete_next = 1'b1;
          end else begin
            cur_next   = cur + 32'd1;
            phase_next = {1'b0, FC_ADDRESS};
          end
        end else begin
          phase_next = {1'b0, code + 4'd1};
        end
      end
    end

    fres.result_status = ST_OK;
    fres.field_code    = code;
    fres.param_index   = (code >= FC_ADDRESS) ? cur : '0;
    fres.record_done   = complete_next;

    // truncation reports the field in progress after this byte
    e_valid            = item.end_of_buffer && !complete_next;
    eres               = '0;
    eres.result_status = ST_TRUNC;
    eres.field_code    = phase_next[3:0];
    eres.param_index   = (phase_next[3:0] >= FC_ADDRESS) ? cur_next : '0;

    if (item.end_of_buffer) begin
      phase_next    = PHASE_START;
      biw_next      = '0;
      acc_next      = '0;
      left_next     = '0;
      params_next   = '0;
      cur_next      = '0;
      pos_next      = '0;
      origin_next   = '0;
      complete_next = 1'b0;
    end
  end

  assign res0    = f_valid ? fres : eres;
  assign res1    = eres;
  assign res_cnt = {1'b0, f_valid} + {1'b0, e_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PHASE_START;
      biw      <= '0;
      acc      <= '0;
      left     <= '0;
      params   <= '0;
      cur      <= '0;
      pos      <= '0;
      origin   <= '0;
      complete <= 1'b0;
    end else if (step) begin
      phase    <= phase_next;
      biw      <= biw_next;
      acc      <= acc_next;
      left     <= left_next;
      params   <= params_next;
      cur      <= cur_next;
      pos      <= pos_next;
      origin   <= origin_next;
      complete <= complete_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/rfp_out_buf.sv
// result register pair of the record field parser and the output stream
// depends on rfp_pkg
`default_nettype none

module rfp_out_buf
  import rfp_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire rfp_result_t               res0,
  input  wire rfp_result_t               res1,
  input  wire logic [1:0]                res_cnt,
  output logic                           can_take,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [TDATA_OUT_BITS-1:0]      m_tdata,
  output logic                           m_tuser,
  output logic                           m_tlast
);

  rfp_result_t slot0, slot1;
  logic [1:0]  cnt;
  logic        pop;

  assign m_tvalid = (cnt != 2'd0);
  assign m_tlast  = (cnt == 2'd1);
  assign pop      = m_tvalid && m_tready;
  assign can_take = (cnt == 2'd0) || ((cnt == 2'd1) && m_tready);

  assign m_tuser = slot0.result_status;
  assign m_tdata = {3'b000, slot0.record_done, slot0.string_start, slot0.field_value,
                    slot0.param_index, slot0.field_code};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (step) begin
      cnt <= res_cnt;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

`default_nettype wire

FILE: design/plugin_record_field_parser.sv
// top level of the record field parser: input register, schema walker, result buffer
// depends on rfp_pkg, rfp_in_reg, rfp_walker, rfp_out_buf
//
// usage:
//   slave side takes one transaction per buffer byte: s_tdata is the byte, s_tuser
//   says a byte is present, s_tlast marks the end of the buffer after that byte.
//   master side gives one transaction per decoded field, and a truncation result
//   (m_tuser high) when the buffer ends before the record is complete; m_tlast
//   marks the final result caused by one input transaction.
// path: an accepted byte waits in the input register; its first result is then
//   registered in the result registers and shown on the master side once they are free.
// throughput: one byte per cycle while m_tready is high; the only limit is the result
//   register pair, which drains one result a cycle, so an end-of-buffer byte that yields
//   a field and a truncation result holds the input until its first result has drained.
// stalls: with m_tready low the block still takes one more byte into its input
//   register; s_tready drops once that register holds a byte and a result waits.
// reset: rst (synchronous) clears the walker to the start of a record and empties
//   both registers; the end-of-buffer marker does the same for the walker.
`default_nettype none

module plugin_record_field_parser
  import rfp_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [7:0]                s_tdata,  // data_byte
  input  wire logic                      s_tuser,  // has_byte
  input  wire logic                      s_tlast,  // end_of_buffer
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // field_code, param_index, field_value, string_start, record_done, zero pad
  output logic [TDATA_OUT_BITS-1:0]      m_tdata,
  output logic                           m_tuser,  // result_status
  output logic                           m_tlast   // last_result
);

  rfp_item_t   item;
  logic        item_valid;
  logic        step;
  logic        can_take;
  rfp_result_t res0, res1;
  logic [1:0]  res_cnt;

  assign step = item_valid && can_take;

  rfp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .step       (step),
    .item       (item),
    .item_valid (item_valid)
  );

  rfp_walker #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_walker (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (item),
    .res0    (res0),
    .res1    (res1),
    .res_cnt (res_cnt)
  );

  rfp_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .res0     (res0),
    .res1     (res1),
    .res_cnt  (res_cnt),
    .can_take (can_take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // a truncation result always closes the results of its byte
  a_trunc_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_TRUNC) |-> m_tlast)
    else $error("truncation result not last");

  // nothing follows the field that completes the record
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[TD_DONE_BIT] |-> m_tlast && (m_tuser == ST_OK))
    else $error("record done result not last");

  // input back-pressure only while results are waiting
  a_stall_has_results: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

endmodule

`default_nettype wire
